FILE: design/pidt_pkg.sv
// Shared types and constants for the packet id duplicate tracker.
package pidt_pkg;

  // Table geometry
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = IDX_W + 1;

  // Field widths
  localparam int unsigned ID_W = 31;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned TTL_W = 16;
  localparam int unsigned RET_W = 7;
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned M_TDATA_W = 72;

  localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(10);

  // Item kinds carried on tuser
  typedef enum logic {
    CMD_PACKET  = 1'b0,
    CMD_CLEANUP = 1'b1
  } item_cmd_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PKT_SCAN,
    ST_PKT_UPD,
    ST_CLN_TEST,
    ST_CLN_SCAN,
    ST_CLN_EVAL,
    ST_FINISH
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;
    logic scan_clr;
    logic scan_run;
    logic pkt_update;
    logic cln_test;
    logic cln_retire;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic cln_run;
    logic retire_ok;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/pidt_ctrl.sv
// Controller state machine sequencing table scans, updates and cleanup passes.
module pidt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_cmd_i,
  output logic                   in_ready_o,
  input  pidt_pkg::dp_status_t   status_i,
  output pidt_pkg::ctrl_cmd_t    cmd_o
);

  pidt_pkg::ctrl_state_e state_q, state_d;
  logic                  accept;

  assign accept = in_valid_i && (state_q == pidt_pkg::ST_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pidt_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == pidt_pkg::CMD_CLEANUP) begin
            state_d = pidt_pkg::ST_CLN_TEST;
          end else begin
            state_d = pidt_pkg::ST_PKT_SCAN;
          end
        end
      end
      pidt_pkg::ST_PKT_SCAN: begin
        if (status_i.scan_done) state_d = pidt_pkg::ST_PKT_UPD;
      end
      pidt_pkg::ST_PKT_UPD: state_d = pidt_pkg::ST_FINISH;
      pidt_pkg::ST_CLN_TEST: begin
        state_d = status_i.cln_run ? pidt_pkg::ST_CLN_SCAN : pidt_pkg::ST_FINISH;
      end
      pidt_pkg::ST_CLN_SCAN: begin
        if (status_i.scan_done) state_d = pidt_pkg::ST_CLN_EVAL;
      end
      pidt_pkg::ST_CLN_EVAL: begin
        state_d = status_i.retire_ok ? pidt_pkg::ST_CLN_SCAN : pidt_pkg::ST_FINISH;
      end
      pidt_pkg::ST_FINISH: begin
        if (status_i.out_free) state_d = pidt_pkg::ST_IDLE;
      end
      default: state_d = pidt_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      pidt_pkg::ST_IDLE: begin
        cmd_o.latch_in = accept;
        cmd_o.scan_clr = accept;
      end
      pidt_pkg::ST_PKT_SCAN: cmd_o.scan_run = 1'b1;
      pidt_pkg::ST_PKT_UPD:  cmd_o.pkt_update = 1'b1;
      pidt_pkg::ST_CLN_TEST: begin
        cmd_o.cln_test = 1'b1;
        cmd_o.scan_clr = 1'b1;
      end
      pidt_pkg::ST_CLN_SCAN: cmd_o.scan_run = 1'b1;
      pidt_pkg::ST_CLN_EVAL: begin
        // retire the smallest aged id and rescan
        cmd_o.cln_retire = status_i.retire_ok;
        cmd_o.scan_clr   = status_i.retire_ok;
      end
      pidt_pkg::ST_FINISH: cmd_o.load_out = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  assign in_ready_o = (state_q == pidt_pkg::ST_IDLE);

endmodule

FILE: design/pidt_dp.sv
// Datapath: gap table memories, valid bits, scan accumulators and result register.
module pidt_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pidt_pkg::ctrl_cmd_t                  cmd_i,
  output pidt_pkg::dp_status_t                 status_o,
  input  logic                                 in_cmd_i,
  input  logic [pidt_pkg::S_TDATA_W-1:0]       in_data_i,
  input  logic                                 cfg_we_i,
  input  logic [pidt_pkg::TTL_W-1:0]           cfg_wdata_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [pidt_pkg::M_TDATA_W-1:0]       out_data_o
);

  localparam int unsigned N     = pidt_pkg::TABLE_ENTRIES;
  localparam int unsigned IDX_W = pidt_pkg::IDX_W;
  localparam int unsigned CNT_W = pidt_pkg::CNT_W;
  localparam int unsigned ID_W  = pidt_pkg::ID_W;
  localparam int unsigned TM_W  = pidt_pkg::TIME_W;
  localparam int unsigned TTL_W = pidt_pkg::TTL_W;
  localparam int unsigned RET_W = pidt_pkg::RET_W;

  // Gap table storage
  logic [ID_W-1:0] id_mem   [N];
  logic [TM_W-1:0] time_mem [N];
  logic [N-1:0]    valid_q;

  // Item and tracker state
  logic             cmd_q;
  logic [ID_W-1:0]  id_q, cm_q, hs_q;
  logic [TM_W-1:0]  now_q, last_q;
  logic [TTL_W-1:0] ttl_q;

  // Scan pipeline
  logic [CNT_W-1:0] sc_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [ID_W-1:0]  rd_id_q;
  logic [TM_W-1:0]  rd_time_q;

  // Scan accumulators
  logic             found_q, free_q, best_vld_q;
  logic [IDX_W-1:0] found_idx_q, free_idx_q, best_idx_q;
  logic [ID_W-1:0]  best_id_q;
  logic [TM_W-1:0]  best_time_q;

  // Result fields
  logic             seen_q, dropped_q, ran_q;
  logic [RET_W-1:0] retired_q;
  logic             out_vld_q;
  logic [pidt_pkg::M_TDATA_W-1:0] out_data_q;

  logic             ent_v, scan_more, is_next, run_ok, retire_ok, seen_d;
  logic             mem_we, valid_set, valid_clr;
  logic [IDX_W-1:0] set_idx, clr_idx;

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      id_mem[free_idx_q]   <= id_q;
      time_mem[free_idx_q] <= now_q;
    end
    rd_id_q   <= id_mem[sc_q[IDX_W-1:0]];
    rd_time_q <= time_mem[sc_q[IDX_W-1:0]];
  end

  // Combinational decisions
  assign ent_v     = valid_q[rd_idx_q];
  assign scan_more = (sc_q < CNT_W'(N));
  assign is_next   = ({1'b0, id_q} == ({1'b0, cm_q} + (ID_W+1)'(1)));
  assign run_ok    = (({1'b0, last_q} + (TM_W+1)'(ttl_q)) <= {1'b0, now_q});
  assign retire_ok = best_vld_q &&
                     (({1'b0, best_time_q} + (TM_W+1)'(ttl_q)) <= {1'b0, now_q});
  assign seen_d    = (id_q <= cm_q) ? 1'b1 : ((id_q > hs_q) ? 1'b0 : found_q);

  // Table writes for packet recording and retirement
  always_comb begin
    mem_we    = 1'b0;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    set_idx   = free_idx_q;
    clr_idx   = found_idx_q;
    if (cmd_i.pkt_update) begin
      if (is_next) begin
        valid_clr = found_q;
      end else if ((id_q > cm_q) && !found_q && free_q) begin
        mem_we    = 1'b1;
        valid_set = 1'b1;
      end
    end else if (cmd_i.cln_retire) begin
      valid_clr = 1'b1;
      clr_idx   = best_idx_q;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (valid_set) valid_q[set_idx] <= 1'b1;
      if (valid_clr) valid_q[clr_idx] <= 1'b0;
    end
  end

  // Scan counter and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q        <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      best_vld_q  <= 1'b0;
      found_idx_q <= '0;
      free_idx_q  <= '0;
      best_idx_q  <= '0;
      best_id_q   <= '0;
      best_time_q <= '0;
    end else if (cmd_i.scan_clr) begin
      sc_q       <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      free_q     <= 1'b0;
      best_vld_q <= 1'b0;
    end else if (cmd_i.scan_run) begin
      if (scan_more) sc_q <= sc_q + CNT_W'(1);
      rd_vld_q <= scan_more;
      rd_idx_q <= sc_q[IDX_W-1:0];
      if (rd_vld_q) begin
        if (ent_v && (rd_id_q == id_q)) begin
          found_q     <= 1'b1;
          found_idx_q <= rd_idx_q;
        end
        if (!ent_v && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= rd_idx_q;
        end
        if (ent_v && (!best_vld_q || (rd_id_q < best_id_q))) begin
          best_vld_q  <= 1'b1;
          best_idx_q  <= rd_idx_q;
          best_id_q   <= rd_id_q;
          best_time_q <= rd_time_q;
        end
      end
    end
  end

  // Item capture, tracker state and result fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= 1'b0;
      id_q      <= '0;
      now_q     <= '0;
      ttl_q     <= pidt_pkg::TTL_RESET;
      cm_q      <= '0;
      hs_q      <= '0;
      last_q    <= '0;
      seen_q    <= 1'b0;
      dropped_q <= 1'b0;
      ran_q     <= 1'b0;
      retired_q <= '0;
    end else begin
      if (cfg_we_i) ttl_q <= cfg_wdata_i;
      if (cmd_i.latch_in) begin
        cmd_q <= in_cmd_i;
        id_q  <= in_data_i[ID_W-1:0];
        now_q <= in_data_i[ID_W +: TM_W];
      end
      if (cmd_i.pkt_update) begin
        seen_q    <= seen_d;
        dropped_q <= !is_next && (id_q > cm_q) && !found_q && !free_q;
        ran_q     <= 1'b0;
        retired_q <= '0;
        if (is_next) cm_q <= id_q;
        if (id_q > hs_q) hs_q <= id_q;
      end
      if (cmd_i.cln_test) begin
        seen_q    <= 1'b0;
        dropped_q <= 1'b0;
        retired_q <= '0;
        ran_q     <= run_ok;
        if (run_ok) last_q <= now_q;
      end
      if (cmd_i.cln_retire) begin
        cm_q <= best_id_q;
        if (retired_q != {RET_W{1'b1}}) retired_q <= retired_q + RET_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {hs_q, cm_q, retired_q, ran_q, dropped_q, seen_q};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  assign status_o.scan_done = !scan_more && !rd_vld_q;
  assign status_o.cln_run   = run_ok && (cmd_q == pidt_pkg::CMD_CLEANUP);
  assign status_o.retire_ok = retire_ok;
  assign status_o.out_free  = !out_vld_q || out_ready_i;

endmodule

FILE: design/packet_id_duplicate_tracker_top.sv
// Top level of the packet id duplicate tracker: controller plus datapath.
// Packet item: accept, a full table scan, an update step, then the result load.
// Cleanup item: a due test, then if due one table scan per retired id plus a final one,
// each followed by an evaluate step; the single-port table is walked one entry at a time.
// One item at a time; the next one is accepted while a result waits for transfer.
// Reset (rst_ni low, async) clears valid bits, ids, cleanup time; timeout returns to 10.
module packet_id_duplicate_tracker_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pidt_pkg::TTL_W-1:0]         cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [30:0] packet_id, [62:31] now_seconds, [63] zero
  input  logic [pidt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] cmd
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] seen_before, [1] insert_dropped, [2] cleanup_ran, [9:3] retired_count,
  // [40:10] contiguous_id, [71:41] highest_id
  output logic [pidt_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

  pidt_pkg::ctrl_cmd_t  cmd;
  pidt_pkg::dp_status_t status;

  pidt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pidt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_cmd_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

FILE: design/pidt_checker.sv
// Port-level checks for the packet id duplicate tracker, bound to the top level.
module pidt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pidt_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One item at a time: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // Retirements only come from a cleanup that ran
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[9:3] != 7'd0) |-> m_axis_tdata[2])
    else $error("retired ids without cleanup");

  // Packet flags never appear on a cleanup result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[0] && !m_axis_tdata[1])
    else $error("packet flags on cleanup result");

  // Contiguous id never passes the highest id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[40:10] <= m_axis_tdata[71:41]))
    else $error("contiguous id above highest id");

endmodule

bind packet_id_duplicate_tracker_top pidt_checker u_pidt_checker (.*);
